// ===== rtl/core/point_in_polygon_test_core_assert.svh =====
// Assertion macros shared by the point-in-polygon core RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define PIPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define PIPT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/pipt_pkg.sv =====
// Package for the point-in-polygon core: command codes, register index, state
// encoding and the control group passed to the edge unit. No dependencies.
`default_nettype none

package pipt_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Word index of a register, taken from paddr[2].
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } pipt_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic first;
    } pipt_vtx_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pipt_vertex_mem.sv =====
// Vertex store of the point-in-polygon core: one synchronous memory holding
// the x and y coordinates of each vertex, one write and one registered read port.
`default_nettype none

module pipt_vertex_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pipt_edge_unit.sv =====
// Edge test pipeline of the point-in-polygon core: straddle check, two exact
// cross products and the crossing-parity flag. Depends on pipt_pkg.
`default_nettype none

module pipt_edge_unit
    import pipt_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pipt_vtx_ctl_t                ctl,
    input  wire logic signed [COORD_BITS-1:0] vtx_x,
    input  wire logic signed [COORD_BITS-1:0] vtx_y,
    input  wire logic signed [COORD_BITS-1:0] pt_x,
    input  wire logic signed [COORD_BITS-1:0] pt_y,
    output logic                              busy,
    output logic                              parity
);

    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [DW-1:0]         dl_reg, dy_reg, dr_reg, ey_reg;
    logic signed [DW-1:0]         dl_next, dy_next, dr_next, ey_next;
    logic signed [PW-1:0]         lp_reg, rp_reg;
    logic                         s1_v_reg, s2_v_reg, neg_reg, parity_reg;
    logic                         s1_v_next, toggle;

    always_comb
    begin
        dl_next   = DW'(pt_x) - DW'(vtx_x);
        dy_next   = DW'(prev_y_reg) - DW'(vtx_y);
        dr_next   = DW'(prev_x_reg) - DW'(vtx_x);
        ey_next   = DW'(pt_y) - DW'(vtx_y);
        s1_v_next = ctl.valid && !ctl.first &&
                    ((vtx_y <= pt_y && pt_y < prev_y_reg) ||
                     (prev_y_reg <= pt_y && pt_y < vtx_y));
        toggle    = s2_v_reg && ((!neg_reg && lp_reg < rp_reg) ||
                                 (neg_reg && lp_reg > rp_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prev_x_reg <= vtx_x;
            prev_y_reg <= vtx_y;
        end
        dl_reg  <= dl_next;
        dy_reg  <= dy_next;
        dr_reg  <= dr_next;
        ey_reg  <= ey_next;
        lp_reg  <= dl_reg * dy_reg;
        rp_reg  <= dr_reg * ey_reg;
        neg_reg <= dy_reg[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s1_v_reg;
            if (ctl.clear)
            begin
                parity_reg <= 1'b0;
            end
            else if (toggle)
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    assign busy   = s1_v_reg || s2_v_reg;
    assign parity = parity_reg;

endmodule

`default_nettype wire

// ===== rtl/core/point_in_polygon_test_core.sv =====
// Point-in-polygon core by crossing parity: vertex memory, edge pipeline,
// sequencer, APB register and output register. Depends on pipt_pkg,
// pipt_vertex_mem, pipt_edge_unit and point_in_polygon_test_core_assert.svh.
//
// A load beat writes one vertex into the vertex memory.
// A query beat reads vertex_count-1 and then vertices 0 to vertex_count-1
// through the single read port of the vertex memory, one per cycle, and
// tests each edge in a three-stage pipeline. Beats are stalled while a query
// is in progress, and its result waits to be loaded while an earlier result
// is still stalled at the output. vertex_count above MAX_VERTICES acts as
// MAX_VERTICES. Vertices used by a query must have been loaded; the memory
// is not cleared by reset. A finished result waits in the output register
// while new beats are accepted.
`default_nettype none

module point_in_polygon_test_core
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic                         command,
    input  wire logic [IDX_W-1:0]             vertex_index,
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic                              inside_res
);

    pipt_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, n_reg, n_next, rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]             n_sat, n_minus1, rd_cnt_minus1;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                         rd_valid_reg, rd_first_reg;
    logic                         rsp_valid_reg, inside_reg;
    logic                         req_accept, query_accept, load_accept, cfg_write;
    logic                         rd_en, rsp_load, edge_busy, edge_parity;
    logic [IDX_W-1:0]             rd_addr;
    logic [2*COORD_BITS-1:0]      rd_data;
    pipt_vtx_ctl_t                vtx_ctl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata    = (paddr[2] == REG_VERTEX_COUNT) ? 32'(count_reg) : 32'd0;

    assign req_stall    = (state_reg != ST_IDLE);
    assign req_accept   = req_valid && !req_stall;
    assign query_accept = req_accept && (command == CMD_QUERY);
    assign load_accept  = req_accept && (command == CMD_LOAD) &&
                          ({1'b0, vertex_index} < (IDX_W + 1)'(MAX_VERTICES));

    assign n_sat         = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_reg;
    assign n_minus1      = n_reg - 1'b1;
    assign rd_cnt_minus1 = rd_cnt_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        rd_cnt_next = rd_cnt_reg;
        rd_en       = 1'b0;
        rd_addr     = rd_cnt_minus1[IDX_W-1:0];
        rsp_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    n_next      = n_sat;
                    rd_cnt_next = '0;
                    state_next  = (n_sat == '0) ? ST_DRAIN : ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en       = 1'b1;
                rd_addr     = (rd_cnt_reg == '0) ? n_minus1[IDX_W-1:0]
                                                 : rd_cnt_minus1[IDX_W-1:0];
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !edge_busy && (!rsp_valid_reg || !rsp_stall))
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en && (rd_cnt_reg == '0);
            if (cfg_write)
            begin
                count_reg <= pwdata[CNT_W-1:0];
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (rsp_load)
        begin
            inside_reg <= edge_parity;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign inside_res = inside_reg;

    pipt_vertex_mem #(
        .DEPTH  (MAX_VERTICES),
        .DATA_W (2 * COORD_BITS)
    ) u_vertex_mem (
        .clk     (clk),
        .wr_en   (load_accept),
        .wr_addr (vertex_index),
        .wr_data ({coord_y, coord_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign vtx_ctl.clear = query_accept;
    assign vtx_ctl.valid = rd_valid_reg;
    assign vtx_ctl.first = rd_first_reg;

    pipt_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (vtx_ctl),
        .vtx_x  (rd_data[COORD_BITS-1:0]),
        .vtx_y  (rd_data[2*COORD_BITS-1:COORD_BITS]),
        .pt_x   (qx_reg),
        .pt_y   (qy_reg),
        .busy   (edge_busy),
        .parity (edge_parity)
    );

`include "point_in_polygon_test_core_assert.svh"

    `PIPT_ASSERT(a_result_after_drain, rsp_load |-> (!rd_valid_reg && !edge_busy), "result taken before pipeline drained")
    `PIPT_ASSERT_NEVER(a_no_overwrite, rsp_load && rsp_valid_reg && rsp_stall, "pending result overwritten")
    `PIPT_ASSERT(a_read_bound, (state_reg == ST_READ) |-> (rd_cnt_reg <= n_reg), "read counter past vertex count")
    `PIPT_ASSERT(a_idle_quiet, (state_reg == ST_IDLE) |-> (!rd_valid_reg && !edge_busy), "edge work while idle")

endmodule

`default_nettype wire
